/* hdl/assert_macros.svh */
// Assertion helper macros used by the checker file.
// No dependencies; every use supplies its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent true implies consequent true in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/bhst_pkg.sv */
// Shared types and constants for the block heat score table.
// No dependencies.
`timescale 1ns / 1ps

package bhst_pkg;

  // field widths of the stored command word (cover the largest parameter values)
  localparam int BLK_FW  = 16;
  localparam int SLOT_FW = 10;

  localparam logic [51:0] MASK52 = {52{1'b1}};
  localparam logic [47:0] MASK48 = {48{1'b1}};

  // configuration register indexes
  localparam logic [1:0] CFG_HEAD_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_TABLE_COUNT = 2'd1;
  localparam logic [1:0] CFG_PREF_FIRST  = 2'd2;
  localparam logic [1:0] CFG_PREF_COUNT  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  typedef enum logic [2:0] {
    OP_PUBLISH  = 3'd0,
    OP_EXTRACT  = 3'd1,
    OP_INCR     = 3'd2,
    OP_DECAY    = 3'd3,
    OP_QUERY    = 3'd4,
    OP_SWAP     = 3'd5,
    OP_PIN      = 3'd6,
    OP_PROMOTE  = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_RD, S_EXE, S_DEC, S_PRO,
    S_SWRA, S_SWRC, S_SWWA, S_SWWC, S_DONE
  } state_t;

  typedef struct packed {
    logic [4:0] head_shift;
    logic [8:0] table_block_count;
    logic [7:0] preferred_first_block;
    logic [8:0] preferred_block_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] block_number;
    logic [31:0] byte_offset;
    logic [31:0] byte_length;
    logic [47:0] operand_value;
    logic [31:0] second_block;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [47:0] score_out;
    logic        cold_valid;
    logic [7:0]  cold_block;
    logic [51:0] cold_total;
    logic        hot_valid;
    logic [7:0]  hot_block;
    logic [51:0] hot_total;
  } out_t;

  // classified command word held in the queue
  typedef struct packed {
    op_t                func;
    logic               loc_ok;
    logic               val_ok;
    logic               same_blk;
    logic               rng_ok;
    logic [BLK_FW-1:0]  blk;
    logic [BLK_FW-1:0]  blk2;
    logic [SLOT_FW-1:0] slot;
    logic [47:0]        val;
  } cmd_t;

  // back end status toward the top level
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

/* hdl/bhst_front.sv */
// Front end: checks the location and arguments of an incoming word and
// builds the command word for the queue. Depends on bhst_pkg.
`timescale 1ns / 1ps

module bhst_front import bhst_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_SLOTS = 16
) (
  input  cfg_t cfg,
  input  in_t  in_word,
  output cmd_t cmd
);

  logic [63:0] head_sz, blk_sz, off64, len64, shifted;
  logic [31:0] nb;
  logic        blk_in, blk2_in, loc_ok;
  op_t         func;

  assign func = op_t'(in_word.func);

  // covered block count, capped at the table size
  assign nb = (32'(cfg.table_block_count) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS)
                                                             : 32'(cfg.table_block_count);

  // head geometry
  always_comb begin
    head_sz = 64'd1 << cfg.head_shift;
    blk_sz  = 64'(BLOCK_SLOTS) << cfg.head_shift;
    off64   = 64'(in_word.byte_offset);
    len64   = 64'(in_word.byte_length);
    shifted = off64 >> cfg.head_shift;
  end

  assign blk_in  = in_word.block_number < nb;
  assign blk2_in = in_word.second_block < nb;
  assign loc_ok  = (len64 == head_sz) && (off64 < blk_sz) &&
                   ((off64 & (head_sz - 64'd1)) == 64'd0) &&
                   (off64 + head_sz <= blk_sz) && blk_in;

  // classify
  always_comb begin
    cmd          = '0;
    cmd.func     = func;
    cmd.loc_ok   = loc_ok;
    cmd.same_blk = in_word.block_number == in_word.second_block;
    cmd.blk      = in_word.block_number[BLK_FW-1:0];
    cmd.blk2     = in_word.second_block[BLK_FW-1:0];
    cmd.slot     = shifted[SLOT_FW-1:0];
    cmd.val      = in_word.operand_value;
    case (func)
      OP_INCR:  cmd.val_ok = in_word.operand_value != 48'd0;
      OP_DECAY: cmd.val_ok = (in_word.operand_value != 48'd0) &&
                             (in_word.operand_value[47:16] == 32'd0);
      default:  cmd.val_ok = 1'b1;
    endcase
    case (func)
      OP_SWAP: cmd.rng_ok = blk_in && blk2_in;
      default: cmd.rng_ok = blk_in;
    endcase
  end

endmodule

/* hdl/bhst_cmd_fifo.sv */
// Two-entry command queue between the front and back ends.
// Depends on bhst_pkg for the command word.
`timescale 1ns / 1ps

module bhst_cmd_fifo import bhst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = ent_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule

/* hdl/bhst_back.sv */
// Back end: slot store, pin map and the sequencer that carries out commands.
// Depends on bhst_pkg.
`timescale 1ns / 1ps

module bhst_back import bhst_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  cmd_t       q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output back_stat_t stat,
  output logic       out_strobe,
  output out_t       out_word
);

  localparam int DEPTH = NUM_BLOCKS * BLOCK_SLOTS;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int BCW   = $clog2(NUM_BLOCKS + 1);
  localparam logic [IW:0]   DEPTH_C = (IW + 1)'(DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(BLOCK_SLOTS - 1);

  function automatic logic [IW-1:0] slot_addr(input logic [31:0] b, input logic [31:0] s);
    logic [31:0] t;
    t = b * 32'(BLOCK_SLOTS) + s;
    return t[IW-1:0];
  endfunction

  // store: {occupied, score}
  logic [48:0] mem [DEPTH];
  logic [48:0] rdata_r;
  logic        mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [48:0] mem_wd;

  logic [NUM_BLOCKS-1:0] pin_r;
  logic                  pin_set, pin_clr;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic [BCW-1:0] rblk_r, rblk_nxt, dblk_r, dblk_nxt;
  logic [SW-1:0] rslot_r, rslot_nxt, dslot_r, dslot_nxt;
  logic          dval_r, dval_nxt;
  logic [51:0]   acc_tot_r, acc_tot_nxt;
  logic          acc_full_r, acc_full_nxt;
  logic [48:0]   hold_r, hold_nxt;
  out_t          res_r, res_nxt;
  logic          strobe_r;

  logic [BCW-1:0] nb;
  logic          rd_go, first, last, full_n, pref, pin_hit;
  logic [52:0]   tot_sum;
  logic [51:0]   tot_n;
  logic [48:0]   inc_sum;
  logic [63:0]   prod;
  logic [IW-1:0] sidx, aidx, cidx;

  assign nb = (32'(cfg.table_block_count) > 32'(NUM_BLOCKS)) ? BCW'(NUM_BLOCKS)
                                                             : BCW'(cfg.table_block_count);

  assign sidx = slot_addr(32'(cmd_r.blk), 32'(cmd_r.slot));
  assign aidx = slot_addr(32'(cmd_r.blk), 32'(cnt_r[SW-1:0]));
  assign cidx = slot_addr(32'(cmd_r.blk2), 32'(cnt_r[SW-1:0]));

  // arithmetic on the word read last cycle
  assign inc_sum = {1'b0, rdata_r[47:0]} + {1'b0, cmd_r.val};
  assign prod    = 64'(rdata_r[47:0]) * 64'(cmd_r.val[15:0]);

  // promotion accumulation
  assign rd_go   = rblk_r < nb;
  assign first   = dslot_r == '0;
  assign last    = dslot_r == LAST_SLOT;
  assign tot_sum = {1'b0, (first ? 52'd0 : acc_tot_r)} + 53'(rdata_r[47:0]);
  assign tot_n   = tot_sum[52] ? MASK52 : tot_sum[51:0];
  assign full_n  = (first | acc_full_r) & rdata_r[48];
  assign pin_hit = pin_r[dblk_r[BW-1:0]];
  assign pref    = (32'(dblk_r) >= 32'(cfg.preferred_first_block)) &&
                   ((32'(dblk_r) - 32'(cfg.preferred_first_block)) <
                    32'(cfg.preferred_block_count));

  assign stat.clearing = state_r == S_CLEAR;
  assign out_strobe    = strobe_r;
  assign out_word      = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (cnt_r == DEPTH_C - 1'b1) state_nxt = S_IDLE;
      S_IDLE:  if (!q_empty) state_nxt = S_DISP;
      S_DISP: begin
        case (cmd_r.func)
          OP_PUBLISH, OP_EXTRACT, OP_QUERY: state_nxt = cmd_r.loc_ok ? S_RD : S_DONE;
          OP_INCR:    state_nxt = (cmd_r.val_ok && cmd_r.loc_ok) ? S_RD : S_DONE;
          OP_DECAY:   state_nxt = cmd_r.val_ok ? S_DEC : S_DONE;
          OP_SWAP:    state_nxt = (!cmd_r.same_blk && cmd_r.rng_ok) ? S_SWRA : S_DONE;
          OP_PROMOTE: state_nxt = S_PRO;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_RD:    state_nxt = S_EXE;
      S_EXE:   state_nxt = S_DONE;
      S_DEC:   if (cnt_r == DEPTH_C) state_nxt = S_DONE;
      S_PRO:   if (!rd_go && !dval_r) state_nxt = S_DONE;
      S_SWRA:  state_nxt = S_SWRC;
      S_SWRC:  state_nxt = S_SWWA;
      S_SWWA:  state_nxt = S_SWWC;
      S_SWWC:  state_nxt = (cnt_r[SW-1:0] == LAST_SLOT) ? S_DONE : S_SWRA;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop        = 1'b0;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    rblk_nxt     = rblk_r;
    rslot_nxt    = rslot_r;
    dval_nxt     = 1'b0;
    dblk_nxt     = rblk_r;
    dslot_nxt    = rslot_r;
    acc_tot_nxt  = acc_tot_r;
    acc_full_nxt = acc_full_r;
    hold_nxt     = hold_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_wa       = sidx;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = sidx;
    pin_set      = 1'b0;
    pin_clr      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = cnt_r[IW-1:0];
        cnt_nxt = cnt_r + 1'b1;
      end
      S_IDLE: begin
        q_pop   = !q_empty;
        cmd_nxt = q_head;
      end
      S_DISP: begin
        res_nxt   = '0;
        cnt_nxt   = '0;
        rblk_nxt  = '0;
        rslot_nxt = '0;
        case (cmd_r.func)
          OP_PUBLISH, OP_EXTRACT, OP_QUERY:
            if (!cmd_r.loc_ok) res_nxt.status = STAT_INVALID;
          OP_INCR:
            if (!(cmd_r.val_ok && cmd_r.loc_ok)) res_nxt.status = STAT_INVALID;
          OP_DECAY:
            if (!cmd_r.val_ok) res_nxt.status = STAT_INVALID;
          OP_SWAP:
            if (!cmd_r.same_blk && !cmd_r.rng_ok) res_nxt.status = STAT_INVALID;
          OP_PIN:
            pin_set = cmd_r.rng_ok;
          default: ;
        endcase
      end
      S_RD: mem_re = 1'b1;
      S_EXE: begin
        case (cmd_r.func)
          OP_PUBLISH: begin
            if (rdata_r[48]) res_nxt.status = STAT_INVALID;
            else begin
              mem_we = 1'b1;
              mem_wd = {1'b1, cmd_r.val};
            end
          end
          OP_EXTRACT: begin
            if (!rdata_r[48]) res_nxt.status = STAT_EMPTY;
            else begin
              res_nxt.found     = 1'b1;
              res_nxt.score_out = rdata_r[47:0];
              mem_we = 1'b1;
              mem_wd = {1'b0, rdata_r[47:0]};
            end
          end
          OP_INCR: begin
            if (!rdata_r[48]) res_nxt.status = STAT_EMPTY;
            else begin
              mem_we = 1'b1;
              mem_wd = {1'b1, (inc_sum[48] ? MASK48 : inc_sum[47:0])};
            end
          end
          default: begin
            if (!rdata_r[48]) res_nxt.status = STAT_EMPTY;
            else begin
              res_nxt.found     = 1'b1;
              res_nxt.score_out = rdata_r[47:0];
            end
          end
        endcase
      end
      // read slot k while writing back slot k-1
      S_DEC: begin
        mem_re  = cnt_r < DEPTH_C;
        mem_ra  = cnt_r[IW-1:0];
        mem_wa  = IW'(cnt_r - 1'b1);
        mem_we  = (cnt_r != '0) && rdata_r[48];
        mem_wd  = {1'b1, prod[63:16]};
        cnt_nxt = cnt_r + 1'b1;
      end
      // sweep covered blocks, one slot a cycle; the read data is registered before it is summed
      S_PRO: begin
        mem_re   = rd_go;
        mem_ra   = slot_addr(32'(rblk_r), 32'(rslot_r));
        dval_nxt = rd_go;
        if (rd_go) begin
          if (rslot_r == LAST_SLOT) begin
            rslot_nxt = '0;
            rblk_nxt  = rblk_r + 1'b1;
          end else begin
            rslot_nxt = rslot_r + 1'b1;
          end
        end
        if (dval_r) begin
          acc_tot_nxt  = tot_n;
          acc_full_nxt = full_n;
          if (last && full_n && !pin_hit) begin
            if (pref) begin
              if (!res_r.cold_valid || tot_n < res_r.cold_total) begin
                res_nxt.cold_valid = 1'b1;
                res_nxt.cold_block = 8'(dblk_r);
                res_nxt.cold_total = tot_n;
              end
            end else begin
              if (!res_r.hot_valid || tot_n > res_r.hot_total) begin
                res_nxt.hot_valid = 1'b1;
                res_nxt.hot_block = 8'(dblk_r);
                res_nxt.hot_total = tot_n;
              end
            end
          end
        end
        pin_clr = !rd_go && !dval_r;
      end
      S_SWRA: begin
        mem_re = 1'b1;
        mem_ra = aidx;
      end
      S_SWRC: begin
        mem_re   = 1'b1;
        mem_ra   = cidx;
        hold_nxt = rdata_r;
      end
      S_SWWA: begin
        mem_we = 1'b1;
        mem_wa = aidx;
        mem_wd = rdata_r;
      end
      S_SWWC: begin
        mem_we  = 1'b1;
        mem_wa  = cidx;
        mem_wd  = hold_r;
        cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
      dval_r   <= 1'b0;
      pin_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= state_r == S_DONE;
      dval_r   <= dval_nxt;
      if (pin_clr) pin_r <= '0;
      else if (pin_set) pin_r[cmd_r.blk[BW-1:0]] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rblk_r     <= rblk_nxt;
    rslot_r    <= rslot_nxt;
    dblk_r     <= dblk_nxt;
    dslot_r    <= dslot_nxt;
    acc_tot_r  <= acc_tot_nxt;
    acc_full_r <= acc_full_nxt;
    hold_r     <= hold_nxt;
    res_r      <= res_nxt;
  end

  // slot store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

endmodule

/* hdl/block_heat_score_table_core.sv */
// Top level of the block heat score table: config registers, front end,
// command queue and back end. Depends on bhst_pkg, bhst_front, bhst_cmd_fifo, bhst_back.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; each word gives one
// result, shown for one cycle with out_strobe, and the receiver cannot stall
// it. After reset the store is swept clear with busy high. A two-deep queue
// takes words while the back end works; the back end handles one word at a
// time over a single store port. The result strobe is registered from the
// back end's done state.
module block_heat_score_table_core import bhst_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_word,
  output logic       out_strobe,
  output out_t       out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  cfg_t       cfg_r;
  cmd_t       cmd_in, q_head;
  logic       q_pop, q_full, q_empty, push;
  back_stat_t stat;

  assign busy = stat.clearing || q_full;
  assign push = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_shift            <= 5'd12;
      cfg_r.table_block_count     <= 9'd256;
      cfg_r.preferred_first_block <= 8'd0;
      cfg_r.preferred_block_count <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD_SHIFT:  cfg_r.head_shift            <= cfg_wdata[4:0];
        CFG_TABLE_COUNT: cfg_r.table_block_count     <= cfg_wdata;
        CFG_PREF_FIRST:  cfg_r.preferred_first_block <= cfg_wdata[7:0];
        CFG_PREF_COUNT:  cfg_r.preferred_block_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bhst_front #(
    .NUM_BLOCKS(NUM_BLOCKS), .BLOCK_SLOTS(BLOCK_SLOTS)
  ) u_front (
    .cfg(cfg_r), .in_word(in_word), .cmd(cmd_in)
  );

  bhst_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(cmd_in), .pop(q_pop),
    .dout(q_head), .full(q_full), .empty(q_empty)
  );

  bhst_back #(
    .NUM_BLOCKS(NUM_BLOCKS), .BLOCK_SLOTS(BLOCK_SLOTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_head(q_head), .q_empty(q_empty),
    .q_pop(q_pop), .stat(stat), .out_strobe(out_strobe), .out_word(out_word)
  );

endmodule

/* hdl/bhst_checker.sv */
// Port-level checks for the block heat score table, bound to the top level.
// Depends on bhst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bhst_checker import bhst_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_word
);

  logic found_bad;

  assign found_bad = out_word.found && (out_word.status != STAT_OK);

  // handshake lines are always driven to known levels
  `ASSERT_SAME(a_ctrl_known, clk, rst_n, 1'b1, !$isunknown({start, busy}))
  // results never come on consecutive cycles
  `ASSERT_NEXT(a_strobe_gap, clk, rst_n, out_strobe, !out_strobe)
  // status code is always a defined one
  `ASSERT_SAME(a_status_code, clk, rst_n, out_strobe, out_word.status != 2'd3)
  // a returned score only comes with ok status
  `ASSERT_SAME(a_found_ok, clk, rst_n, out_strobe, !found_bad)
  // no score shown unless found
  `ASSERT_SAME(a_score_zero, clk, rst_n, out_strobe && !out_word.found,
               out_word.score_out == 48'd0)

endmodule

bind block_heat_score_table_core bhst_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_word(out_word)
);

/* verif/testbench.sv */
// Self-checking testbench for block_heat_score_table_core.
// Depends on bhst_pkg and the core RTL; it predicts every result word in its own
// copy of the score table and checks the result words field by field.
`timescale 1ns / 1ps

module testbench;
  import bhst_pkg::*;

  localparam int NBLK  = 256;
  localparam int NSLOT = 16;
  localparam int DEPTH = NBLK * NSLOT;
  localparam int WATCHDOG_LIMIT = 40000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_word;
  logic       out_strobe;
  out_t       out_word;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  block_heat_score_table_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow table and registers
  logic [47:0] heat_score [DEPTH];
  logic        heat_occ [DEPTH];
  logic        heat_pin [NBLK];
  logic [4:0]  m_shift;
  logic [8:0]  m_count;
  logic [7:0]  m_pfirst;
  logic [8:0]  m_pcount;

  in_t  cmd_q [$];
  out_t result_q [$];
  int   idle_pct;
  int   err_cnt;
  int   quiet_cycles;

  // append a word to the pending queue
  function automatic void add_cmd(in_t w);
    cmd_q.insert(cmd_q.size(), w);
  endfunction

  function automatic int covered();
    return (m_count > NBLK) ? NBLK : int'(m_count);
  endfunction

  // resolve a head location to a slot index; returns 0 when invalid
  function automatic bit head_slot(logic [31:0] blk, logic [31:0] off, logic [31:0] len,
                                   output int slot);
    logic [63:0] head;
    logic [63:0] blockb;
    head   = 64'd1 << m_shift;
    blockb = 64'(NSLOT) << m_shift;
    slot = 0;
    if (64'(len) != head || 64'(off) >= blockb || (64'(off) & (head - 1)) != 0 ||
        64'(off) + head > blockb)
      return 0;
    if (64'(blk) >= 64'(covered())) return 0;
    slot = int'(blk) * NSLOT + int'(64'(off) >> m_shift);
    return slot < DEPTH;
  endfunction

  // apply one command word to the shadow table and return its result word
  function automatic out_t heat_apply(in_t w);
    out_t        r;
    int          s;
    int          nb;
    int          a;
    int          c;
    int          k;
    bit          ok;
    bit          full;
    bit          pref;
    logic [48:0] sum;
    logic [63:0] prod;
    logic [52:0] total;
    logic [47:0] ts;
    logic        to;
    r  = '0;
    nb = covered();
    ok = head_slot(w.block_number, w.byte_offset, w.byte_length, s);
    case (op_t'(w.func))
      OP_PUBLISH: begin
        if (!ok || heat_occ[s]) r.status = STAT_INVALID;
        else begin
          heat_score[s] = w.operand_value;
          heat_occ[s] = 1'b1;
        end
      end
      OP_EXTRACT: begin
        if (!ok) r.status = STAT_INVALID;
        else if (!heat_occ[s]) r.status = STAT_EMPTY;
        else begin
          r.found = 1'b1;
          r.score_out = heat_score[s];
          heat_occ[s] = 1'b0;
        end
      end
      OP_INCR: begin
        if (w.operand_value == 0 || !ok) r.status = STAT_INVALID;
        else if (!heat_occ[s]) r.status = STAT_EMPTY;
        else begin
          sum = {1'b0, heat_score[s]} + {1'b0, w.operand_value};
          heat_score[s] = sum[48] ? MASK48 : sum[47:0];
        end
      end
      OP_DECAY: begin
        if (w.operand_value == 0 || w.operand_value >= 48'd65536) r.status = STAT_INVALID;
        else
          for (int i = 0; i < DEPTH; i++)
            if (heat_occ[i]) begin
              prod = 64'(heat_score[i]) * 64'(w.operand_value);
              heat_score[i] = prod[63:16];
            end
      end
      OP_QUERY: begin
        if (!ok) r.status = STAT_INVALID;
        else if (!heat_occ[s]) r.status = STAT_EMPTY;
        else begin
          r.found = 1'b1;
          r.score_out = heat_score[s];
        end
      end
      OP_SWAP: begin
        if (w.block_number != w.second_block) begin
          if (64'(w.block_number) >= 64'(nb) || 64'(w.second_block) >= 64'(nb))
            r.status = STAT_INVALID;
          else
            for (int i = 0; i < NSLOT; i++) begin
              a = int'(w.block_number) * NSLOT + i;
              c = int'(w.second_block) * NSLOT + i;
              ts = heat_score[a];
              to = heat_occ[a];
              heat_score[a] = heat_score[c];
              heat_occ[a] = heat_occ[c];
              heat_score[c] = ts;
              heat_occ[c] = to;
            end
        end
      end
      OP_PIN: begin
        if (64'(w.block_number) < 64'(nb)) heat_pin[w.block_number] = 1'b1;
      end
      default: begin
        // promotion: coldest full preferred block, hottest full foreign block
        for (int b = 0; b < nb; b++) begin
          total = '0;
          full = 1'b1;
          for (int i = 0; i < NSLOT; i++) begin
            k = b * NSLOT + i;
            if (!heat_occ[k]) full = 1'b0;
            else begin
              total = total + 53'(heat_score[k]);
              if (total > 53'(MASK52)) total = 53'(MASK52);
            end
          end
          if (full && !heat_pin[b]) begin
            pref = (b >= m_pfirst) && (b - int'(m_pfirst) < int'(m_pcount));
            if (pref) begin
              if (!r.cold_valid || total[51:0] < r.cold_total) begin
                r.cold_valid = 1'b1;
                r.cold_block = b[7:0];
                r.cold_total = total[51:0];
              end
            end else if (!r.hot_valid || total[51:0] > r.hot_total) begin
              r.hot_valid = 1'b1;
              r.hot_block = b[7:0];
              r.hot_total = total[51:0];
            end
          end
        end
        for (int b = 0; b < NBLK; b++) heat_pin[b] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // driver: one word at a time, with random idle cycles
  logic hold_next;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      hold_next = start && busy;
      if (start && !busy) result_q.insert(result_q.size(), heat_apply(in_word));
      if (!hold_next && cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_word <= cmd_q.pop_front();
        start <= 1'b1;
      end else if (!hold_next) begin
        start <= 1'b0;
      end
    end
  end

  // register writes update the shadow registers at the same edge
  always @(posedge clk) begin
    if (rst_n && cfg_we)
      case (cfg_index)
        CFG_HEAD_SHIFT:  m_shift  <= cfg_wdata[4:0];
        CFG_TABLE_COUNT: m_count  <= cfg_wdata;
        CFG_PREF_FIRST:  m_pfirst <= cfg_wdata[7:0];
        CFG_PREF_COUNT:  m_pcount <= cfg_wdata;
        default: ;
      endcase
  end

  task automatic report(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: mismatch on %s: expected %h actual %h", $time, name, want, got);
    err_cnt++;
  endtask

  // monitor: every strobed word is checked against the oldest prediction
  out_t want;
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (result_q.size() == 0) begin
        $display("%0t: result word with no prediction: %h", $time, out_word);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (out_word.status !== want.status) report("status", want.status, out_word.status);
        if (out_word.found !== want.found) report("found", want.found, out_word.found);
        if (out_word.score_out !== want.score_out)
          report("score_out", want.score_out, out_word.score_out);
        if (out_word.cold_valid !== want.cold_valid)
          report("cold_valid", want.cold_valid, out_word.cold_valid);
        if (out_word.cold_block !== want.cold_block)
          report("cold_block", want.cold_block, out_word.cold_block);
        if (out_word.cold_total !== want.cold_total)
          report("cold_total", want.cold_total, out_word.cold_total);
        if (out_word.hot_valid !== want.hot_valid)
          report("hot_valid", want.hot_valid, out_word.hot_valid);
        if (out_word.hot_block !== want.hot_block)
          report("hot_block", want.hot_block, out_word.hot_block);
        if (out_word.hot_total !== want.hot_total)
          report("hot_total", want.hot_total, out_word.hot_total);
      end
    end
  end

  // watchdog: cycles with no accepted word, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_we || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAIL");
      $finish;
    end
  end

  // command word aimed at one slot of one block, location well formed
  function automatic in_t at_slot(op_t op, logic [31:0] blk, int slot, logic [47:0] val);
    in_t w;
    w = '0;
    w.func = op;
    w.block_number = blk;
    w.byte_offset = 32'(slot) << m_shift;
    w.byte_length = 32'd1 << m_shift;
    w.operand_value = val;
    return w;
  endfunction

  function automatic logic [47:0] rand_score();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(1000));
      2: return MASK48 - 48'($urandom_range(3));
      default: return {16'($urandom), 32'($urandom)} >> $urandom_range(40);
    endcase
  endfunction

  // random word: mostly well formed, heavy on publish so blocks fill up
  function automatic in_t rand_word();
    in_t w;
    int  pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 38) op = OP_PUBLISH;
    else if (pick < 48) op = OP_EXTRACT;
    else if (pick < 58) op = OP_INCR;
    else if (pick < 68) op = OP_QUERY;
    else if (pick < 73) op = OP_DECAY;
    else if (pick < 81) op = OP_SWAP;
    else if (pick < 89) op = OP_PIN;
    else op = OP_PROMOTE;
    w = at_slot(op, 32'($urandom_range(covered() - 1)), $urandom_range(NSLOT - 1),
                rand_score());
    w.second_block = 32'($urandom_range(covered() - 1));
    if (op == OP_DECAY)
      w.operand_value = ($urandom_range(9) == 0) ? rand_score() :
                        48'($urandom_range(65535, 1));
    if (op == OP_INCR && $urandom_range(9) == 0) w.operand_value = '0;
    // broken locations and raw noise
    case ($urandom_range(19))
      0: w.byte_length = w.byte_length ^ (32'd1 << $urandom_range(31));
      1: w.byte_offset = w.byte_offset + ((m_shift == 0) ? (32'(NSLOT) << 0) : 32'd1);
      2: w.block_number = 32'(covered()) + $urandom_range(3);
      3: begin
        w.block_number = $urandom;
        w.byte_offset = $urandom;
        w.byte_length = $urandom;
        w.second_block = $urandom;
        w.operand_value = 48'({$urandom, $urandom});
      end
      default: ;
    endcase
    return w;
  endfunction

  // wait until every queued word is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() > 0 || start || result_q.size() > 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [8:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int pct, logic [4:0] hs, logic [8:0] cnt,
                              logic [7:0] pf, logic [8:0] pc);
    drain();
    cfg_write(CFG_HEAD_SHIFT, 9'(hs));
    cfg_write(CFG_TABLE_COUNT, cnt);
    cfg_write(CFG_PREF_FIRST, 9'(pf));
    cfg_write(CFG_PREF_COUNT, pc);
    @(negedge clk);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      // sender holds off once, halfway through, until the table is quiet
      if (i == n / 2) drain();
      add_cmd(rand_word());
    end
  endtask

  initial begin
    in_t w;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_pct = 0;
    err_cnt = 0;
    quiet_cycles = 0;
    m_shift = 5'd12;
    m_count = 9'd256;
    m_pfirst = 8'd0;
    m_pcount = 9'd128;
    for (int i = 0; i < DEPTH; i++) begin
      heat_score[i] = '0;
      heat_occ[i] = 1'b0;
    end
    for (int b = 0; b < NBLK; b++) heat_pin[b] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // let the clearing sweep finish
    do @(negedge clk);
    while (busy);

    // directed words at reset settings
    add_cmd(at_slot(OP_PUBLISH, 0, 0, MASK48));
    add_cmd(at_slot(OP_PUBLISH, 0, 0, 48'd5));        // occupied
    add_cmd(at_slot(OP_QUERY, 0, 0, 0));
    add_cmd(at_slot(OP_INCR, 0, 0, 48'd7));           // saturates
    add_cmd(at_slot(OP_INCR, 0, 0, 48'd0));           // zero amount
    add_cmd(at_slot(OP_INCR, 0, 1, 48'd1));           // empty slot
    add_cmd(at_slot(OP_QUERY, 0, 1, 0));              // empty slot
    add_cmd(at_slot(OP_DECAY, 0, 0, 48'd0));
    add_cmd(at_slot(OP_DECAY, 0, 0, 48'd65536));
    add_cmd(at_slot(OP_DECAY, 0, 0, 48'd65535));
    add_cmd(at_slot(OP_DECAY, 0, 0, 48'd1));
    add_cmd(at_slot(OP_EXTRACT, 0, 0, 0));
    add_cmd(at_slot(OP_EXTRACT, 0, 0, 0));            // now empty
    add_cmd(at_slot(OP_PUBLISH, 255, 15, 48'd9));
    w = at_slot(OP_QUERY, 255, 15, 0); w.byte_length = 32'd4095;  // bad length
    add_cmd(w);
    w = at_slot(OP_QUERY, 255, 15, 0); w.byte_offset = 32'd4097;  // misaligned
    add_cmd(w);
    w = at_slot(OP_QUERY, 255, 0, 0); w.byte_offset = 32'hFFFF_F000; // past block
    add_cmd(w);
    add_cmd(at_slot(OP_QUERY, 32'hFFFF_FFFF, 0, 0));  // block out of range
    w = at_slot(OP_SWAP, 32'hFFFF_FFFF, 0, 0); w.second_block = 32'hFFFF_FFFF;
    add_cmd(w);                                       // equal, out of range
    w = at_slot(OP_SWAP, 3, 0, 0); w.second_block = 32'd256;
    add_cmd(w);                                       // one out of range
    w = at_slot(OP_SWAP, 255, 0, 0); w.second_block = 32'd1;
    add_cmd(w);
    add_cmd(at_slot(OP_QUERY, 1, 15, 0));
    add_cmd(at_slot(OP_PIN, 32'd300, 0, 0));          // ignored
    add_cmd(at_slot(OP_PIN, 1, 0, 0));
    add_cmd(at_slot(OP_PROMOTE, 0, 0, 0));

    // random phases over several settings, extremes included
    random_phase(18, 58, 5'd0, 9'd8, 8'd2, 9'd3);
    for (int i = 0; i < NSLOT; i++) add_cmd(at_slot(OP_PUBLISH, 5, i, rand_score()));
    for (int i = 0; i < NSLOT; i++) add_cmd(at_slot(OP_PUBLISH, 2, i, rand_score()));
    add_cmd(at_slot(OP_PROMOTE, 0, 0, 0));
    random_phase(18, 11, 5'd20, 9'd256, 8'd255, 9'd256);
    random_phase(18, 0, 5'd3, 9'd1, 8'd0, 9'd0);
    for (int i = 0; i < NSLOT; i++) add_cmd(at_slot(OP_PUBLISH, 0, i, rand_score()));
    add_cmd(at_slot(OP_PROMOTE, 0, 0, 0));
    random_phase(15, 58, 5'd1, 9'd4, 8'd1, 9'd2);
    drain();

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
